/* hw/rtl/pfp_pkg.sv */
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared constants, types and helpers of the peak finder with prominence.
// ----------------------------------------------------------------------------
`default_nettype none

package pfp_pkg;

  localparam int MAX_SAMPLES  = 1024;
  localparam int MAX_PEAKS    = 32;

  localparam int SAMPLE_W     = 16;
  localparam int PROM_W       = 16;
  localparam int SPAN_W       = 10;
  localparam int PEAK_INDEX_W = 10;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int CAND_W = $clog2(MAX_PEAKS + 1);
  localparam int SUM_W  = ((CNT_W > SPAN_W) ? CNT_W : SPAN_W) + 1;

  localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HEIGHT_MIN     = 2'd0,
    CFG_PROMINENCE_MIN = 2'd1,
    CFG_NEIGHBOUR_SPAN = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PEAK_RD,
    ST_PEAK_CHK,
    ST_WIN_RD,
    ST_WIN_CHK,
    ST_LW_RD,
    ST_LW_CHK,
    ST_RW_RD,
    ST_RW_CHK,
    ST_EVAL,
    ST_EMIT,
    ST_NEXT,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    RD_I,
    RD_J,
    RD_J_DEC
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    rd_sel_t rd_sel;
    logic    latch_peak;
    logic    win_init;
    logic    j_inc;
    logic    lw_init;
    logic    lw_step;
    logic    rw_init;
    logic    rw_step;
    logic    eval;
    logic    pend_set;
    logic    out_mid;
    logic    out_final;
    logic    i_inc;
  } cmd_t;

  typedef struct packed {
    logic height_ok;
    logic scan_done;
    logic win_done;
    logic j_is_i;
    logic rd_ge_peak;
    logic lw_end;
    logic lw_fall;
    logic rw_end;
    logic rw_fall;
    logic pass;
    logic pend_valid;
    logic out_free;
  } sts_t;

  // low bits of a sample index as reported on the result channel
  function automatic logic [PEAK_INDEX_W-1:0] to_peak_index(input logic [CNT_W-1:0] v);
    logic [CNT_W+PEAK_INDEX_W-1:0] ext;
    ext = {{PEAK_INDEX_W{1'b0}}, v};
    return ext[PEAK_INDEX_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/pfp_sample_if.sv */
// ----------------------------------------------------------------------------
// pfp_sample_if
// Sample stream channel: one spectrum sample per beat, last one marked.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfp_sample_if;
  import pfp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       final_sample;

  modport source(output valid, output sample, output final_sample, input ready);
  modport sink(input valid, input sample, input final_sample, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pfp_result_if.sv */
// ----------------------------------------------------------------------------
// pfp_result_if
// Result channel: one reported peak, or an empty report, per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfp_result_if;
  import pfp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [PEAK_INDEX_W-1:0] peak_index;
  logic                    peak_valid;
  logic                    report_end;

  modport source(output valid, output peak_index, output peak_valid, output report_end,
                 input ready);
  modport sink(input valid, input peak_index, input peak_valid, input report_end,
               output ready);
endinterface

`default_nettype wire

/* hw/rtl/pfp_cfg_if.sv */
// ----------------------------------------------------------------------------
// pfp_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfp_cfg_if;
  import pfp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  wdata;

  modport source(output valid, output reg_index, output wdata, input ready);
  modport sink(input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

/* hw/rtl/peak_finder_with_prominence.sv */
// ----------------------------------------------------------------------------
// peak_finder_with_prominence
// Loads a spectrum, finds strict local maxima and reports those prominent enough.
// ----------------------------------------------------------------------------
// Samples load at one beat per cycle into a 1024-entry sample memory; the beat
// marked final starts the search, during which the sample channel is stalled.
// The search runs through the single read port of that memory: each sample is
// read and checked against the height minimum, its window neighbours bar its
// own slot are read in turn until one is not lower, and each candidate gets
// left and right valley walks, an evaluation and an emit step; a last step
// closes the report. A passing peak waits while the peak held before it cannot
// enter the result register, and the closing beat waits while that register
// holds an earlier beat. A report is one beat per passing peak in index order,
// or a single empty beat, the last one flagged report_end. The result register
// lets loading of the next spectrum begin while the last beat still waits. The
// memory needs no clearing after reset. Configuration writes are taken at any
// time and take effect at once, so they belong between spectra.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_finder_with_prominence (
  input  wire logic     clk,
  input  wire logic     rst,
  pfp_sample_if.sink    samples,
  pfp_result_if.source  results,
  pfp_cfg_if.sink       cfg
);
  import pfp_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  logic                mem_wr_en;
  logic [ADDR_W-1:0]   mem_wr_addr;
  logic [SAMPLE_W-1:0] mem_wr_data;
  logic [ADDR_W-1:0]   mem_rd_addr;
  logic [SAMPLE_W-1:0] mem_rd_data;

  assign cfg.ready = 1'b1;

  pfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_final (samples.final_sample),
    .in_ready (samples.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pfp_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_sample      (samples.sample),
    .in_final       (samples.final_sample),
    .cfg_valid      (cfg.valid),
    .cfg_index      (cfg.reg_index),
    .cfg_data       (cfg.wdata),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data),
    .out_ready      (results.ready),
    .out_valid      (results.valid),
    .out_peak_index (results.peak_index),
    .out_peak_valid (results.peak_valid),
    .out_report_end (results.report_end)
  );

  pfp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_SAMPLES)
  ) u_sample_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

`default_nettype wire

/* hw/rtl/pfp_ram.sv */
// ----------------------------------------------------------------------------
// pfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/pfp_datapath.sv */
// ----------------------------------------------------------------------------
// pfp_datapath
// Scan counters, window and valley registers, config registers, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module pfp_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pfp_pkg::cmd_t                     cmd,
  output pfp_pkg::sts_t                          sts,
  input  wire logic signed [pfp_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                              in_final,
  input  wire logic                              cfg_valid,
  input  wire logic [pfp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [pfp_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                   mem_wr_en,
  output logic [pfp_pkg::ADDR_W-1:0]             mem_wr_addr,
  output logic [pfp_pkg::SAMPLE_W-1:0]           mem_wr_data,
  output logic [pfp_pkg::ADDR_W-1:0]             mem_rd_addr,
  input  wire logic [pfp_pkg::SAMPLE_W-1:0]      mem_rd_data,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic [pfp_pkg::PEAK_INDEX_W-1:0]       out_peak_index,
  output logic                                   out_peak_valid,
  output logic                                   out_report_end
);
  import pfp_pkg::*;

  logic signed [SAMPLE_W-1:0] height_min;
  logic [PROM_W-1:0]          prominence_min;
  logic [SPAN_W-1:0]          neighbour_span;

  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;
  logic                       count_full;
  logic [CNT_W-1:0]           len;
  logic [CNT_W-1:0]           i;
  logic [CNT_W-1:0]           j;
  logic [CNT_W-1:0]           j_dec;
  logic [CNT_W-1:0]           hi;
  logic [CAND_W-1:0]          cand;
  logic signed [SAMPLE_W-1:0] peak;
  logic signed [SAMPLE_W-1:0] left;
  logic signed [SAMPLE_W-1:0] right;
  logic signed [SAMPLE_W-1:0] rd_val;
  logic signed [SAMPLE_W-1:0] valley;
  logic [SAMPLE_W:0]          prom;
  logic                       pass;
  logic                       pend_valid;
  logic [CNT_W-1:0]           pend_idx;
  logic                       out_free;

  logic [SUM_W-1:0]           i_ext;
  logic [SUM_W-1:0]           span_ext;
  logic [SUM_W-1:0]           hi_sum;
  logic [SUM_W-1:0]           last_idx;
  logic [CNT_W-1:0]           lo;
  logic [CNT_W-1:0]           hi_clip;

  assign rd_val = $signed(mem_rd_data);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      height_min     <= '0;
      prominence_min <= '0;
      neighbour_span <= SPAN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_HEIGHT_MIN:     height_min     <= $signed(cfg_data[SAMPLE_W-1:0]);
        CFG_PROMINENCE_MIN: prominence_min <= cfg_data[PROM_W-1:0];
        CFG_NEIGHBOUR_SPAN: neighbour_span <= cfg_data[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // sample loading
  assign count_full  = (count == CNT_W'(MAX_SAMPLES));
  assign count_next  = count_full ? count : count + CNT_W'(1);
  assign mem_wr_en   = cmd.load && !count_full;
  assign mem_wr_addr = count[ADDR_W-1:0];
  assign mem_wr_data = in_sample;

  assign j_dec = j - CNT_W'(1);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_I:     mem_rd_addr = i[ADDR_W-1:0];
      RD_J:     mem_rd_addr = j[ADDR_W-1:0];
      RD_J_DEC: mem_rd_addr = j_dec[ADDR_W-1:0];
      default:  mem_rd_addr = i[ADDR_W-1:0];
    endcase
  end

  // window bounds, clipped at both ends
  assign i_ext    = SUM_W'(i);
  assign span_ext = SUM_W'(neighbour_span);
  assign hi_sum   = i_ext + span_ext;
  assign last_idx = SUM_W'(len) - SUM_W'(1);
  assign hi_clip  = (hi_sum > last_idx) ? last_idx[CNT_W-1:0] : hi_sum[CNT_W-1:0];
  assign lo       = (i_ext > span_ext) ? CNT_W'(i_ext - span_ext) : '0;

  // prominence: peak minus the higher valley, never negative
  assign valley = (left > right) ? left : right;
  assign prom   = {peak[SAMPLE_W-1], peak} - {valley[SAMPLE_W-1], valley};

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      cand       <= '0;
    end else begin
      if (cmd.load) begin
        count <= in_final ? '0 : count_next;
      end
      if (cmd.load && in_final) begin
        cand <= '0;
      end else if (cmd.eval) begin
        cand <= cand + CAND_W'(1);
      end
      if (cmd.pend_set) begin
        pend_valid <= 1'b1;
      end else if (cmd.out_final) begin
        pend_valid <= 1'b0;
      end
      if (cmd.out_mid || cmd.out_final) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_final) begin
      len <= count_next;
      i   <= '0;
    end else if (cmd.i_inc) begin
      i <= i + CNT_W'(1);
    end
    if (cmd.latch_peak) begin
      peak <= rd_val;
    end
    if (cmd.win_init) begin
      j  <= lo;
      hi <= hi_clip;
    end else if (cmd.j_inc || cmd.rw_step) begin
      j <= j + CNT_W'(1);
    end else if (cmd.lw_init) begin
      j <= i;
    end else if (cmd.lw_step) begin
      j <= j_dec;
    end else if (cmd.rw_init) begin
      j <= i + CNT_W'(1);
    end
    if (cmd.lw_init) begin
      left <= peak;
    end else if (cmd.lw_step) begin
      left <= rd_val;
    end
    if (cmd.rw_init) begin
      right <= peak;
    end else if (cmd.rw_step) begin
      right <= rd_val;
    end
    if (cmd.eval) begin
      pass <= (prom >= {1'b0, prominence_min});
    end
    if (cmd.pend_set) begin
      pend_idx <= i;
    end
    if (cmd.out_mid) begin
      out_peak_index <= to_peak_index(pend_idx);
      out_peak_valid <= 1'b1;
      out_report_end <= 1'b0;
    end else if (cmd.out_final) begin
      out_peak_index <= pend_valid ? to_peak_index(pend_idx) : '0;
      out_peak_valid <= pend_valid;
      out_report_end <= 1'b1;
    end
  end

  always_comb begin
    sts.height_ok  = (rd_val >= height_min);
    sts.scan_done  = ((i + CNT_W'(1)) == len) || (cand == CAND_W'(MAX_PEAKS));
    sts.win_done   = (j > hi);
    sts.j_is_i     = (j == i);
    sts.rd_ge_peak = (rd_val >= peak);
    sts.lw_end     = (j == '0);
    sts.lw_fall    = (rd_val < left);
    sts.rw_end     = (j == len);
    sts.rw_fall    = (rd_val < right);
    sts.pass       = pass;
    sts.pend_valid = pend_valid;
    sts.out_free   = out_free;
  end

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_mid || cmd.out_final) |-> out_free)
    else $error("result register overwritten while occupied");

  a_cand_cap: assert property (@(posedge clk) disable iff (rst)
    cand <= CAND_W'(MAX_PEAKS))
    else $error("candidate count beyond capacity");

  a_final_clears_pend: assert property (@(posedge clk) disable iff (rst)
    cmd.out_final |=> (!pend_valid && out_valid && out_report_end))
    else $error("report end beat not formed correctly");

endmodule

`default_nettype wire

/* hw/rtl/pfp_ctrl.sv */
// ----------------------------------------------------------------------------
// pfp_ctrl
// Sequencer: loading, candidate scan, valley walks and report emission.
// ----------------------------------------------------------------------------
`default_nettype none

module pfp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_final,
  output logic               in_ready,
  output pfp_pkg::cmd_t      cmd,
  input  wire pfp_pkg::sts_t sts
);
  import pfp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_I;
    in_ready   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_final) begin
            state_next = ST_PEAK_RD;
          end
        end
      end
      ST_PEAK_RD: begin
        cmd.rd_sel = RD_I;
        state_next = ST_PEAK_CHK;
      end
      ST_PEAK_CHK: begin
        cmd.latch_peak = 1'b1;
        if (sts.height_ok) begin
          cmd.win_init = 1'b1;
          state_next   = ST_WIN_RD;
        end else begin
          state_next = ST_NEXT;
        end
      end
      ST_WIN_RD: begin
        if (sts.win_done) begin
          cmd.lw_init = 1'b1;
          state_next  = ST_LW_RD;
        end else if (sts.j_is_i) begin
          cmd.j_inc = 1'b1;
        end else begin
          cmd.rd_sel = RD_J;
          state_next = ST_WIN_CHK;
        end
      end
      ST_WIN_CHK: begin
        if (sts.rd_ge_peak) begin
          state_next = ST_NEXT;
        end else begin
          cmd.j_inc  = 1'b1;
          state_next = ST_WIN_RD;
        end
      end
      ST_LW_RD: begin
        if (sts.lw_end) begin
          cmd.rw_init = 1'b1;
          state_next  = ST_RW_RD;
        end else begin
          cmd.rd_sel = RD_J_DEC;
          state_next = ST_LW_CHK;
        end
      end
      ST_LW_CHK: begin
        if (sts.lw_fall) begin
          cmd.lw_step = 1'b1;
          state_next  = ST_LW_RD;
        end else begin
          cmd.rw_init = 1'b1;
          state_next  = ST_RW_RD;
        end
      end
      ST_RW_RD: begin
        if (sts.rw_end) begin
          state_next = ST_EVAL;
        end else begin
          cmd.rd_sel = RD_J;
          state_next = ST_RW_CHK;
        end
      end
      ST_RW_CHK: begin
        if (sts.rw_fall) begin
          cmd.rw_step = 1'b1;
          state_next  = ST_RW_RD;
        end else begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // a held peak goes out mid-report only once a later one passes, the last one
        // goes out in the closing beat, so that beat can carry its end flag
        if (!sts.pass) begin
          state_next = ST_NEXT;
        end else if (!sts.pend_valid || sts.out_free) begin
          cmd.pend_set = 1'b1;
          cmd.out_mid  = sts.pend_valid;
          state_next   = ST_NEXT;
        end
      end
      ST_NEXT: begin
        cmd.i_inc  = 1'b1;
        state_next = sts.scan_done ? ST_FINISH : ST_PEAK_RD;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.out_final = 1'b1;
          state_next    = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  a_final_starts_search: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_final) |=> (state == ST_PEAK_RD))
    else $error("final sample did not start the search");

  a_load_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> !sts.pend_valid)
    else $error("held peak left over from the previous report");

  a_finish_returns: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && sts.out_free) |=> (state == ST_LOAD))
    else $error("report end did not return to loading");

endmodule

`default_nettype wire

/* bench/pfp_report_checker.sv */
// ----------------------------------------------------------------------------
// pfp_report_checker
// Watches the sample, configuration and result channels of the peak finder,
// keeps its own copy of the spectrum and the registers, works out the peak
// report for every spectrum and compares each result beat with it.
// ----------------------------------------------------------------------------
module pfp_report_checker (
  input  logic   clk,
  input  logic   rst,
  pfp_sample_if  samples,
  pfp_result_if  results,
  pfp_cfg_if     cfg,
  input  logic   drain_done,
  output int     fail_count,
  output int     reports_done
);
  timeunit 1ns;
  timeprecision 1ps;
  import pfp_pkg::*;

  typedef struct packed {
    logic [PEAK_INDEX_W-1:0] peak_index;
    logic                    peak_valid;
    logic                    report_end;
  } peak_report_t;

  logic signed [SAMPLE_W-1:0] spectrum_mem [MAX_SAMPLES];
  int unsigned                fill_count;
  logic signed [SAMPLE_W-1:0] height_min_q;
  logic [PROM_W-1:0]          prom_min_q;
  logic [SPAN_W-1:0]          span_q;
  peak_report_t               expected_peaks [$];
  bit                         drain_checked;

  // strict maximum over the window, clipped at both ends
  function automatic bit is_window_max(input int unsigned idx, input int unsigned len);
    int unsigned lo, hi, k;
    lo = (idx > span_q) ? idx - span_q : 0;
    hi = idx + span_q;
    if (hi > len - 1) hi = len - 1;
    for (k = lo; k <= hi; k++) begin
      if (k != idx && spectrum_mem[k] >= spectrum_mem[idx]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int prominence_of(input int unsigned idx, input int unsigned len);
    int          peak, left, right;
    int unsigned j;
    peak  = spectrum_mem[idx];
    left  = peak;
    right = peak;
    j = idx;
    while (j > 0 && spectrum_mem[j-1] < left) begin
      left = spectrum_mem[j-1];
      j--;
    end
    j = idx + 1;
    while (j < len && spectrum_mem[j] < right) begin
      right = spectrum_mem[j];
      j++;
    end
    return peak - ((left > right) ? left : right);
  endfunction

  function automatic void predict_report(input int unsigned len);
    int unsigned  picks [$];
    int unsigned  i;
    int           n;
    peak_report_t r;
    n = 0;
    for (i = 0; i < len; i++) begin
      if (picks.size() == MAX_PEAKS) break;
      if (spectrum_mem[i] >= height_min_q && is_window_max(i, len)) begin
        picks.insert(picks.size(), i);
      end
    end
    foreach (picks[k]) begin
      if (prominence_of(picks[k], len) >= int'(prom_min_q)) begin
        r.peak_index = picks[k][PEAK_INDEX_W-1:0];
        r.peak_valid = 1'b1;
        r.report_end = 1'b0;
        expected_peaks.insert(expected_peaks.size(), r);
        n++;
      end
    end
    if (n == 0) begin
      r = '{peak_index: '0, peak_valid: 1'b0, report_end: 1'b1};
      expected_peaks.insert(expected_peaks.size(), r);
    end else begin
      expected_peaks[expected_peaks.size()-1].report_end = 1'b1;
    end
  endfunction

  always @(posedge clk) begin : watch
    peak_report_t want;
    if (rst) begin
      fill_count    = 0;
      height_min_q  = '0;
      prom_min_q    = '0;
      span_q        = SPAN_RESET;
      fail_count    = 0;
      reports_done  = 0;
      drain_checked = 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.reg_index))
          CFG_HEIGHT_MIN:     height_min_q = cfg.wdata;
          CFG_PROMINENCE_MIN: prom_min_q   = cfg.wdata;
          CFG_NEIGHBOUR_SPAN: span_q       = cfg.wdata[SPAN_W-1:0];
          default: ;
        endcase
      end

      if (samples.valid && samples.ready) begin
        // beats past the end of the store are dropped, a final one still searches
        if (fill_count < MAX_SAMPLES) begin
          spectrum_mem[fill_count] = samples.sample;
          fill_count++;
        end
        if (samples.final_sample) begin
          predict_report(fill_count);
          fill_count = 0;
        end
      end

      if (results.valid && results.ready) begin
        if (results.report_end) reports_done++;
        if (expected_peaks.size() == 0) begin
          $error("unexpected result beat: peak_index %0d peak_valid %0b report_end %0b",
                 results.peak_index, results.peak_valid, results.report_end);
          fail_count++;
        end else begin
          want = expected_peaks.pop_front();
          if (results.peak_index !== want.peak_index) begin
            $error("peak_index: expected %0d, got %0d", want.peak_index, results.peak_index);
            fail_count++;
          end
          if (results.peak_valid !== want.peak_valid) begin
            $error("peak_valid: expected %0b, got %0b", want.peak_valid, results.peak_valid);
            fail_count++;
          end
          if (results.report_end !== want.report_end) begin
            $error("report_end: expected %0b, got %0b", want.report_end, results.report_end);
            fail_count++;
          end
        end
      end

      if (drain_done && !drain_checked) begin
        drain_checked = 1'b1;
        if (expected_peaks.size() != 0) begin
          $error("%0d expected result beats never arrived", expected_peaks.size());
          fail_count += expected_peaks.size();
        end
      end
    end
  end

endmodule

/* bench/tb_peak_finder_with_prominence.sv */
// ----------------------------------------------------------------------------
// tb_peak_finder_with_prominence
// Drives spectra and register writes into the peak finder: a directed set of
// corner spectra (single sample, ties, full-scale values, candidate overflow),
// then random spectra under several register settings and pacing modes. The
// report checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_peak_finder_with_prominence;
  timeunit 1ns;
  timeprecision 1ps;
  import pfp_pkg::*;

  typedef enum {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

  logic clk = 1'b0;
  logic rst;
  logic drain_done;
  int   fail_count;
  int   reports_done;
  int   reports_sent;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   random_beats;

  logic signed [SAMPLE_W-1:0] spectrum_q [$];

  pfp_sample_if sample_ch ();
  pfp_result_if result_ch ();
  pfp_cfg_if    cfg_ch ();

  peak_finder_with_prominence u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  pfp_report_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .samples      (sample_ch),
    .results      (result_ch),
    .cfg          (cfg_ch),
    .drain_done   (drain_done),
    .fail_count   (fail_count),
    .reports_done (reports_done)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] height, input logic [CFG_DATA_W-1:0] prom,
                            input logic [CFG_DATA_W-1:0] span_word);
    write_reg(CFG_HEIGHT_MIN, height);
    write_reg(CFG_PROMINENCE_MIN, prom);
    write_reg(CFG_NEIGHBOUR_SPAN, span_word);
    cfg_ch.valid <= 1'b0;
  endtask

  // one beat per entry of spectrum_q, the last one marked final
  task automatic send_spectrum();
    foreach (spectrum_q[i]) begin
      while ($urandom_range(99) < send_idle_pct) begin
        sample_ch.valid <= 1'b0;
        @(posedge clk);
      end
      sample_ch.valid        <= 1'b1;
      sample_ch.sample       <= spectrum_q[i];
      sample_ch.final_sample <= (i == spectrum_q.size() - 1);
      do @(posedge clk); while (!sample_ch.ready);
    end
    reports_sent++;
  endtask

  // all reports back, then a short pause before touching the registers
  task automatic wait_reports();
    sample_ch.valid <= 1'b0;
    while (reports_done != reports_sent) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic make_spectrum();
    int len, style, v, i;
    len   = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
    style = $urandom_range(9);
    v     = int'($urandom_range(65535)) - 32768;
    spectrum_q.delete();
    for (i = 0; i < len; i++) begin
      case (style)
        0, 1: v = int'($urandom_range(65535)) - 32768;
        2, 3: v = $urandom_range(2);
        4, 5: v = ($urandom_range(3) == 0) ? int'($urandom_range(65535)) - 32768
                                            : int'($urandom_range(200)) - 100;
        default: begin
          v = v + int'($urandom_range(8000)) - 4000;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
        end
      endcase
      spectrum_q.insert(spectrum_q.size(), SAMPLE_W'(v));
    end
  endtask

  task automatic random_config();
    logic [CFG_DATA_W-1:0] height, prom;
    logic [SPAN_W-1:0]     span;
    case ($urandom_range(9))
      0:          height = 16'h8000;
      1:          height = 16'h7FFF;
      2, 3, 4, 5: height = CFG_DATA_W'(int'($urandom_range(4000)) - 2000);
      default:    height = CFG_DATA_W'($urandom);
    endcase
    case ($urandom_range(9))
      0:       prom = '0;
      1:       prom = 16'hFFFF;
      7, 8, 9: prom = CFG_DATA_W'($urandom);
      default: prom = CFG_DATA_W'($urandom_range(3000));
    endcase
    case ($urandom_range(7))
      0:       span = '0;
      1:       span = '1;
      default: span = SPAN_W'($urandom_range(1, 5));
    endcase
    // upper bits of the span word are junk the block must ignore
    set_config(height, prom, {6'($urandom), span});
  endtask

  initial begin
    rst                    <= 1'b1;
    drain_done             <= 1'b0;
    sample_ch.valid        <= 1'b0;
    sample_ch.sample       <= '0;
    sample_ch.final_sample <= 1'b0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.reg_index       <= CFG_HEIGHT_MIN;
    cfg_ch.wdata           <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    reports_sent   = 0;
    random_beats   = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset register values: single sample, full-scale peak, flat, mixed
    spectrum_q = '{5};
    send_spectrum();
    spectrum_q = '{-32768, 32767, -32768};
    send_spectrum();
    spectrum_q = '{0, 0, 0};
    send_spectrum();
    spectrum_q = '{3, 1, 2, -5, 7};
    send_spectrum();
    wait_reports();

    // top thresholds, span zero
    set_config(16'h7FFF, 16'hFFFF, 16'h0000);
    spectrum_q = '{32767};
    send_spectrum();
    spectrum_q = '{-32768, 32767, -32768};
    send_spectrum();
    wait_reports();

    // widest window, all-ones span word
    set_config(16'h8000, 16'h0000, 16'hFFFF);
    spectrum_q = '{3, 1, 2, -5, 7};
    send_spectrum();
    wait_reports();

    // span zero makes every sample a candidate: capacity cuts the scan
    set_config(16'h8000, 16'h0000, 16'h0000);
    spectrum_q.delete();
    repeat (34) spectrum_q.insert(spectrum_q.size(), SAMPLE_W'($urandom));
    send_spectrum();
    wait_reports();

    for (int p = 0; p < 4; p++) begin
      case (pace_t'(p))
        PACE_FULL:        begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        PACE_SEND_GAPS:   begin send_idle_pct = 59; recv_stall_pct = 0;  end
        PACE_RECV_STALLS: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        PACE_BOTH:        begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      repeat (3) begin
        random_config();
        random_beats = 0;
        while (random_beats < 25) begin
          make_spectrum();
          random_beats += spectrum_q.size();
          send_spectrum();
        end
        wait_reports();
      end
    end

    repeat (50) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("peak_finder_with_prominence regression: pass");
    end else begin
      $display("peak_finder_with_prominence regression: fail");
    end
    $finish;
  end

  initial begin
    #16_000_000;
    $display("peak_finder_with_prominence regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/pfp_pkg.sv
hw/rtl/pfp_sample_if.sv
hw/rtl/pfp_result_if.sv
hw/rtl/pfp_cfg_if.sv
hw/rtl/pfp_ram.sv
hw/rtl/pfp_datapath.sv
hw/rtl/pfp_ctrl.sv
hw/rtl/peak_finder_with_prominence.sv
bench/pfp_report_checker.sv
bench/tb_peak_finder_with_prominence.sv
